// ----- hw/rtl/mhd_pkg.sv -----
// Shared types and constants for the motor mode and H-bridge drive unit.
// No dependencies; imported by motor_mode_and_hbridge_drive_unit.
package mhd_pkg;

  localparam int SPD_W   = 16;
  localparam int DUTY_W  = 16;
  localparam int CMD_W   = 3;
  localparam int MODE_W  = 3;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;
  localparam int OUT_BITS = 3 * DUTY_W + MODE_W + SPD_W;
  localparam int OUT_DW  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic signed [SPD_W-1:0] MAX_SPEED_RST = 16'sd10000;
  localparam logic signed [SPD_W-1:0] MIN_SPEED_RST = -16'sd10000;
  localparam logic [DUTY_W-1:0]       MAX_DUTY_RST  = 16'd10000;
  localparam logic [DUTY_W-1:0]       MIN_DUTY_RST  = 16'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_SPEED = 3'd0,
    CMD_ENCODER   = 3'd1,
    CMD_START     = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_SLEEP     = 3'd4,
    CMD_WAKE      = 3'd5,
    CMD_BRAKE     = 3'd6,
    CMD_DIRECT    = 3'd7
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_STOPPED  = 3'd0,
    MODE_RUNNING  = 3'd1,
    MODE_SLEEPING = 3'd2,
    MODE_NSTOP    = 3'd3,
    MODE_FSTOP    = 3'd4
  } mode_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_MAX_SPEED   = 3'd0,
    REG_MIN_SPEED   = 3'd1,
    REG_MAX_DUTY    = 3'd2,
    REG_MIN_DUTY    = 3'd3,
    REG_DRIVER_TYPE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] speed_now;
    logic [MODE_W-1:0]       mode;
    logic [DUTY_W-1:0]       drive_magnitude;
    logic [DUTY_W-1:0]       duty_b;
    logic [DUTY_W-1:0]       duty_a;
  } result_t;

  function automatic logic signed [SPD_W-1:0] clamp_speed(
    input logic signed [SPD_W-1:0] v,
    input logic signed [SPD_W-1:0] hi,
    input logic signed [SPD_W-1:0] lo
  );
    logic signed [SPD_W-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/motor_mode_and_hbridge_drive_unit.sv -----
// Motor mode controller with two-channel H-bridge duty outputs.
// Depends on mhd_pkg for command/mode codes, register indexes and the result type.
//
// Usage:
//   Input beats (in_*) carry a command in in_tuser and a signed 16-bit value in
//   in_tdata. Each beat yields exactly one result beat (out_*) carrying the held
//   duties, drive magnitude, mode and cached encoder speed.
//   Configuration registers (speed limits, duty levels, driver type) are written
//   through cfg_we/cfg_addr/cfg_wdata; the user must write them only while no
//   beats are in flight, which the block itself does not enforce. Throughput: one
//   beat per cycle while in_tready is high; mode and drive state update in the
//   cycle a beat is accepted, so consecutive beats see each other's effects.
//   A result register plus a one-entry skid register decouple the sides: with
//   the receiver stalled, one more input beat is taken, then in_tready drops
//   until the result register drains. No beat is dropped or repeated.
//   Reset (rst_n low, synchronous) returns the mode to stopped, clears speed,
//   magnitude and duties, reloads register defaults and empties both buffers.
module motor_mode_and_hbridge_drive_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,   // value[15:0]
  input  logic [2:0]                in_tuser,   // cmd[2:0]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [mhd_pkg::OUT_DW-1:0] out_tdata, // duty_a, duty_b, drive_magnitude,
                                                // mode, speed_now, zero pad
  input  logic                      cfg_we,
  input  logic [mhd_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mhd_pkg::CFG_DW-1:0] cfg_wdata
);
  import mhd_pkg::*;

  logic signed [SPD_W-1:0] max_speed_r;
  logic signed [SPD_W-1:0] min_speed_r;
  logic [DUTY_W-1:0]       max_duty_r;
  logic [DUTY_W-1:0]       min_duty_r;
  logic                    driver_type_r;

  mode_t                   mode_r, mode_nxt;
  logic signed [SPD_W-1:0] speed_r, speed_nxt;
  logic [DUTY_W-1:0]       mag_r, mag_nxt;
  logic [DUTY_W-1:0]       duty_a_r, duty_a_nxt;
  logic [DUTY_W-1:0]       duty_b_r, duty_b_nxt;

  logic                    out_valid_r, skd_valid_r;
  result_t                 out_data_r, skd_data_r;
  result_t                 res;

  logic                    push, pop;
  cmd_t                    cmd;
  logic signed [SPD_W-1:0] val;
  logic signed [SPD_W-1:0] target;
  logic signed [SPD_W-1:0] drv_v;
  logic                    do_drive;
  logic signed [SPD_W+1:0] sum_a;

  assign in_tready  = !skd_valid_r;
  assign push       = in_tvalid && in_tready;
  assign pop        = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_data_r);

  assign cmd    = cmd_t'(in_tuser);
  assign val    = $signed(in_tdata);
  assign target = clamp_speed(val, max_speed_r, min_speed_r);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r   <= MAX_SPEED_RST;
      min_speed_r   <= MIN_SPEED_RST;
      max_duty_r    <= MAX_DUTY_RST;
      min_duty_r    <= MIN_DUTY_RST;
      driver_type_r <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MAX_SPEED:   max_speed_r   <= $signed(cfg_wdata);
        REG_MIN_SPEED:   min_speed_r   <= $signed(cfg_wdata);
        REG_MAX_DUTY:    max_duty_r    <= cfg_wdata;
        REG_MIN_DUTY:    min_duty_r    <= cfg_wdata;
        REG_DRIVER_TYPE: driver_type_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // mode next state
  always_comb begin
    mode_nxt = mode_r;
    case (cmd)
      CMD_SET_SPEED: begin
        if (mode_r == MODE_FSTOP || (mode_r == MODE_NSTOP && speed_r == '0)) begin
          mode_nxt = MODE_STOPPED;
        end
      end
      CMD_START: if (mode_r == MODE_STOPPED) mode_nxt = MODE_RUNNING;
      CMD_STOP: begin
        if (mode_r == MODE_RUNNING || mode_r == MODE_SLEEPING) mode_nxt = MODE_NSTOP;
      end
      CMD_SLEEP: if (mode_r == MODE_RUNNING) mode_nxt = MODE_SLEEPING;
      CMD_WAKE:  if (mode_r == MODE_SLEEPING) mode_nxt = MODE_RUNNING;
      CMD_BRAKE: mode_nxt = MODE_FSTOP;
      default: ;
    endcase
  end

  // speed cache and bridge drive
  always_comb begin
    speed_nxt = speed_r;
    do_drive  = 1'b0;
    drv_v     = '0;
    case (cmd)
      CMD_SET_SPEED: begin
        do_drive = 1'b1;
        drv_v    = (mode_r == MODE_RUNNING) ? target : '0;
      end
      CMD_ENCODER: speed_nxt = target;
      CMD_DIRECT: begin
        do_drive = 1'b1;
        drv_v    = val;
      end
      default: ;
    endcase

    sum_a      = $signed({2'b00, max_duty_r}) + (SPD_W+2)'(drv_v);
    mag_nxt    = mag_r;
    duty_a_nxt = duty_a_r;
    duty_b_nxt = duty_b_r;
    if (do_drive) begin
      mag_nxt = drv_v[SPD_W-1] ? DUTY_W'(-drv_v) : DUTY_W'(drv_v);
      if (drv_v > 0) begin
        duty_a_nxt = mag_nxt;
        duty_b_nxt = min_duty_r;
      end else if (!driver_type_r) begin
        duty_a_nxt = mag_nxt;
        duty_b_nxt = max_duty_r;
      end else begin
        duty_a_nxt = sum_a[SPD_W+1] ? '0 : sum_a[DUTY_W-1:0];
        duty_b_nxt = max_duty_r;
      end
    end

    res.duty_a          = duty_a_nxt;
    res.duty_b          = duty_b_nxt;
    res.drive_magnitude = mag_nxt;
    res.mode            = mode_nxt;
    res.speed_now       = speed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_STOPPED;
      speed_r  <= '0;
      mag_r    <= '0;
      duty_a_r <= '0;
      duty_b_r <= '0;
    end else if (push) begin
      mode_r   <= mode_nxt;
      speed_r  <= speed_nxt;
      mag_r    <= mag_nxt;
      duty_a_r <= duty_a_nxt;
      duty_b_r <= duty_b_nxt;
    end
  end

  // result register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skd_valid_r) begin
        out_valid_r <= 1'b1;
        skd_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skd_valid_r) begin
        out_data_r <= skd_data_r;
      end else if (push) begin
        out_data_r <= res;
      end
    end else if (push) begin
      skd_data_r <= res;
    end
  end

endmodule
